// ===== sv/ulb_pkg.sv =====
package ulb_pkg;

  localparam int unsigned CodeBits = 21;

  localparam logic [1:0] CLASS_SPACE = 2'd0;
  localparam logic [1:0] CLASS_WORD  = 2'd1;
  localparam logic [1:0] CLASS_OTHER = 2'd2;

  localparam logic [CodeBits-1:0] CP_TAB      = 21'h00009;
  localparam logic [CodeBits-1:0] CP_LF       = 21'h0000A;
  localparam logic [CodeBits-1:0] CP_CR       = 21'h0000D;
  localparam logic [CodeBits-1:0] CP_SPACE    = 21'h00020;
  localparam logic [CodeBits-1:0] CP_IDEO_SPC = 21'h03000;

  typedef struct packed {
    logic       break_before;
    logic       space;
    logic [1:0] char_class;
    logic       newline;
  } ulb_class_t;

  function automatic logic is_spacing(input logic [CodeBits-1:0] c);
    return (c == CP_SPACE) || (c == CP_TAB) || (c == CP_IDEO_SPC);
  endfunction

  function automatic logic is_ideo(input logic [CodeBits-1:0] c);
    return (c >= 21'h01100 && c <= 21'h011FF) || (c >= 21'h02E80 && c <= 21'h09FFF) ||
           (c >= 21'h0A000 && c <= 21'h0A4CF) || (c >= 21'h0AC00 && c <= 21'h0D7AF) ||
           (c >= 21'h0F900 && c <= 21'h0FAFF) || (c >= 21'h0FF00 && c <= 21'h0FF60) ||
           (c >= 21'h20000 && c <= 21'h3FFFD);
  endfunction

  // closing punctuation that may not start a line
  function automatic logic no_line_start(input logic [CodeBits-1:0] c);
    logic r;
    case (c) inside
      21'h03001, 21'h03002, 21'h0FF0C, 21'h0FF0E, 21'h0FF1A, 21'h0FF1B, 21'h0FF01,
      21'h0FF1F, 21'h0FF09, 21'h0FF3D, 21'h0FF5D, 21'h0300D, 21'h0300F, 21'h03009,
      21'h0300B, 21'h0201D, 21'h02019, 21'h00029, 21'h0005D, 21'h0007D, 21'h0002C,
      21'h0002E, 21'h0003B, 21'h0003A, 21'h00021, 21'h0003F: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // opening punctuation that may not end a line
  function automatic logic no_line_end(input logic [CodeBits-1:0] c);
    logic r;
    case (c) inside
      21'h0FF08, 21'h0FF3B, 21'h0FF5B, 21'h0300C, 21'h0300E, 21'h03008, 21'h0300A,
      21'h0201C, 21'h02018, 21'h00028, 21'h0005B, 21'h0007B: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ulb_classify.sv =====
module ulb_classify (
  input  logic [ulb_pkg::CodeBits-1:0] prev_i,
  input  logic [ulb_pkg::CodeBits-1:0] code_i,
  output ulb_pkg::ulb_class_t          class_o
);
  import ulb_pkg::*;

  logic nl;
  logic brk;
  logic word;

  always_comb begin
    nl = (code_i == CP_LF);
    if (prev_i == '0 || is_spacing(code_i)) begin
      brk = 1'b0;
    end else if (no_line_start(code_i) || no_line_end(prev_i)) begin
      brk = 1'b0;
    end else if (is_spacing(prev_i)) begin
      brk = 1'b1;
    end else begin
      brk = is_ideo(prev_i) || is_ideo(code_i);
    end

    word = (code_i >= 21'h61 && code_i <= 21'h7A) || (code_i >= 21'h41 && code_i <= 21'h5A) ||
           (code_i >= 21'h30 && code_i <= 21'h39) || (code_i == 21'h5F) ||
           (code_i >= 21'h80);

    class_o.break_before = brk && !nl;
    class_o.space        = is_spacing(code_i);
    class_o.newline      = nl;
    if (is_spacing(code_i) || nl || code_i == CP_CR) begin
      class_o.char_class = CLASS_SPACE;
    end else if (is_ideo(code_i)) begin
      class_o.char_class = CLASS_OTHER;
    end else if (word) begin
      class_o.char_class = CLASS_WORD;
    end else begin
      class_o.char_class = CLASS_OTHER;
    end
  end

endmodule

// ===== sv/utf8_line_break_classifier.sv =====
// UTF-8 decoder with line break classification. One text byte is taken per
// cycle, and one result appears for each codepoint, in the cycle after its last
// byte (or after the byte flagged end_of_text, where missing continuation
// bytes count as zero). Decoding and all break and class rules are done in
// a single registered pass, so a byte can be accepted in every cycle; the
// only stall is a full result register whose result is not taken. Bytes that
// are not valid leads are passed through as one-byte codepoints. Offsets
// count in OFFSET_BITS bits and wrap; start_offset gives the low 16 bits.
// The end-of-text byte returns offset and break history to their reset state.
module utf8_line_break_classifier #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   text_byte_i,
  input  logic                         end_of_text_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ulb_pkg::CodeBits-1:0] code_point_o,
  output logic [15:0]                  start_offset_o,
  output logic [2:0]                   byte_length_o,
  output logic                         break_before_o,
  output logic                         space_flag_o,
  output logic [1:0]                   char_class_o,
  output logic                         newline_flag_o,
  output logic                         final_flag_o
);
  import ulb_pkg::*;

  logic [CodeBits-1:0]    prev_q, prev_d;
  logic [CodeBits-1:0]    part_q, part_d;
  logic [1:0]             rem_q, rem_d;
  logic [2:0]             len_q, len_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   out_valid_q, out_valid_d;

  logic [CodeBits-1:0]    part_new;
  logic [1:0]             rem_new;
  logic [2:0]             len_new;
  logic [OFFSET_BITS-1:0] start_new;
  logic [OFFSET_BITS+15:0] start_ext;
  logic                   accept;
  logic                   emit;
  ulb_class_t             cls;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    len_new   = len_q;
    start_new = start_q;
    if (rem_q == 2'd0) begin
      start_new = pos_q;
      if ((text_byte_i & 8'hE0) == 8'hC0) begin
        len_new  = 3'd2;
        part_new = {10'b0, text_byte_i[4:0], 6'b0};
      end else if ((text_byte_i & 8'hF0) == 8'hE0) begin
        len_new  = 3'd3;
        part_new = {5'b0, text_byte_i[3:0], 12'b0};
      end else if ((text_byte_i & 8'hF8) == 8'hF0) begin
        len_new  = 3'd4;
        part_new = {text_byte_i[2:0], 18'b0};
      end else begin
        len_new  = 3'd1;
        part_new = {13'b0, text_byte_i};
      end
      rem_new = 2'(len_new - 3'd1);
    end else begin
      rem_new = rem_q - 2'd1;
      case (rem_new)
        2'd0:    part_new = part_q | {15'b0, text_byte_i[5:0]};
        2'd1:    part_new = part_q | {9'b0, text_byte_i[5:0], 6'b0};
        2'd2:    part_new = part_q | {3'b0, text_byte_i[5:0], 12'b0};
        default: part_new = part_q;
      endcase
    end
    emit = (rem_new == 2'd0) || end_of_text_i;
  end

  ulb_classify u_classify (
    .prev_i  (prev_q),
    .code_i  (part_new),
    .class_o (cls)
  );

  assign start_ext = {16'b0, start_new};

  always_comb begin
    prev_d  = prev_q;
    part_d  = part_q;
    rem_d   = rem_q;
    len_d   = len_q;
    pos_d   = pos_q;
    start_d = start_q;
    if (accept) begin
      pos_d   = pos_q + 1'b1;
      len_d   = len_new;
      start_d = start_new;
      if (emit) begin
        part_d = '0;
        rem_d  = 2'd0;
        prev_d = cls.newline ? '0 : part_new;
      end else begin
        part_d = part_new;
        rem_d  = rem_new;
      end
      if (end_of_text_i) begin
        prev_d  = '0;
        len_d   = 3'd1;
        pos_d   = '0;
        start_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      part_q      <= '0;
      rem_q       <= 2'd0;
      len_q       <= 3'd1;
      pos_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      part_q      <= part_d;
      rem_q       <= rem_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register, loaded per emitted transaction
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      code_point_o   <= part_new;
      start_offset_o <= start_ext[15:0];
      byte_length_o  <= len_new;
      break_before_o <= cls.break_before;
      space_flag_o   <= cls.space;
      char_class_o   <= cls.char_class;
      newline_flag_o <= cls.newline;
      final_flag_o   <= end_of_text_i;
    end
  end

  assign out_valid_o = out_valid_q;

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_length_o != 3'd0) && (byte_length_o <= 3'd4))
    else $error("byte length out of range");

  a_nl_no_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && newline_flag_o |-> !break_before_o && char_class_o == CLASS_SPACE)
    else $error("break before newline");

  a_space_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && space_flag_o |-> char_class_o == CLASS_SPACE && !break_before_o)
    else $error("space misclassified");

  a_rem_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd0 |-> len_q > {1'b0, rem_q})
    else $error("remaining count exceeds sequence length");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_text_i |=> pos_q == '0 && prev_q == '0 && rem_q == 2'd0)
    else $error("end of text did not clear state");

endmodule

// ===== tb/sv/testbench.sv =====
import ulb_pkg::*;

typedef struct packed {
  logic [CodeBits-1:0] code;
  logic [15:0]         start;
  logic [2:0]          len;
  logic                brk;
  logic                blank;
  logic [1:0]          cls;
  logic                lf;
  logic                last;
} cp_result_t;

class line_break_scoreboard;
  cp_result_t          pending[$];
  int unsigned         errors;
  int unsigned         checked;
  logic [CodeBits-1:0] prev_cp;
  logic [CodeBits-1:0] partial;
  logic [1:0]          remaining;
  logic [2:0]          seq_len;
  logic [15:0]         pos;
  logic [15:0]         seq_start;

  function new();
    errors  = 0;
    checked = 0;
    clear();
  endfunction

  function void clear();
    prev_cp   = '0;
    partial   = '0;
    remaining = '0;
    seq_len   = 3'd1;
    pos       = '0;
    seq_start = '0;
  endfunction

  function bit is_blank(logic [CodeBits-1:0] c);
    return c == CP_SPACE || c == CP_TAB || c == CP_IDEO_SPC;
  endfunction

  function bit is_cjk(logic [CodeBits-1:0] c);
    return (c >= 'h1100 && c <= 'h11FF) || (c >= 'h2E80 && c <= 'h9FFF) ||
           (c >= 'hA000 && c <= 'hA4CF) || (c >= 'hAC00 && c <= 'hD7AF) ||
           (c >= 'hF900 && c <= 'hFAFF) || (c >= 'hFF00 && c <= 'hFF60) ||
           (c >= 'h20000 && c <= 'h3FFFD);
  endfunction

  function bit forbids_start(logic [CodeBits-1:0] c);
    case (c)
      'h3001, 'h3002, 'hFF0C, 'hFF0E, 'hFF1A, 'hFF1B, 'hFF01, 'hFF1F, 'hFF09,
      'hFF3D, 'hFF5D, 'h300D, 'h300F, 'h3009, 'h300B, 'h201D, 'h2019,
      'h29, 'h5D, 'h7D, 'h2C, 'h2E, 'h3B, 'h3A, 'h21, 'h3F: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function bit forbids_end(logic [CodeBits-1:0] c);
    case (c)
      'hFF08, 'hFF3B, 'hFF5B, 'h300C, 'h300E, 'h3008, 'h300A, 'h201C, 'h2018,
      'h28, 'h5B, 'h7B: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function bit may_break(logic [CodeBits-1:0] p, logic [CodeBits-1:0] n);
    if (p == 0 || is_blank(n) || forbids_start(n) || forbids_end(p)) return 1'b0;
    if (is_blank(p)) return 1'b1;
    return is_cjk(p) || is_cjk(n);
  endfunction

  function logic [1:0] class_of(logic [CodeBits-1:0] c);
    if (is_blank(c) || c == CP_LF || c == CP_CR) return CLASS_SPACE;
    if (is_cjk(c)) return CLASS_OTHER;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
        c == "_" || c >= 'h80) return CLASS_WORD;
    return CLASS_OTHER;
  endfunction

  // decode one accepted byte and queue the codepoint it completes, if any
  function void note_byte(logic [7:0] b, logic last);
    bit         done;
    cp_result_t r;
    if (remaining == 0) begin
      seq_start = pos;
      if (b[7:5] == 3'b110) begin
        seq_len = 3'd2;
        partial = {10'd0, b[4:0], 6'd0};
      end else if (b[7:4] == 4'b1110) begin
        seq_len = 3'd3;
        partial = {5'd0, b[3:0], 12'd0};
      end else if (b[7:3] == 5'b11110) begin
        seq_len = 3'd4;
        partial = {b[2:0], 18'd0};
      end else begin
        seq_len = 3'd1;
        partial = {13'd0, b};
      end
      remaining = 2'(seq_len - 3'd1);
    end else begin
      remaining = remaining - 2'd1;
      partial = partial | (21'(b[5:0]) << (6 * remaining));
    end
    done = (remaining == 0);
    pos = pos + 16'd1;
    if (!done && !last) return;
    r.code  = partial;
    r.start = seq_start;
    r.len   = seq_len;
    r.lf    = (partial == CP_LF);
    r.brk   = !r.lf && may_break(prev_cp, partial);
    r.blank = is_blank(partial);
    r.cls   = class_of(partial);
    r.last  = last;
    pending.insert(pending.size(), r);
    prev_cp   = r.lf ? '0 : partial;
    partial   = '0;
    remaining = '0;
    if (last) clear();
  endfunction

  function void compare(string name, logic [CodeBits-1:0] e, logic [CodeBits-1:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, g);
    end
  endfunction

  function void check_result(cp_result_t got);
    cp_result_t e;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected codepoint %0h, expected none", $time, got.code);
      return;
    end
    e = pending.pop_front();
    checked++;
    compare("code_point", e.code, got.code);
    compare("start_offset", e.start, got.start);
    compare("byte_length", e.len, got.len);
    compare("break_before", e.brk, got.brk);
    compare("space_flag", e.blank, got.blank);
    compare("char_class", e.cls, got.cls);
    compare("newline_flag", e.lf, got.lf);
    compare("final_flag", e.last, got.last);
  endfunction
endclass

module testbench;
  localparam int unsigned StallLimit = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          text_byte_i = '0;
  logic                end_of_text_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [CodeBits-1:0] code_point_o;
  logic [15:0]         start_offset_o;
  logic [2:0]          byte_length_o;
  logic                break_before_o;
  logic                space_flag_o;
  logic [1:0]          char_class_o;
  logic                newline_flag_o;
  logic                final_flag_o;

  line_break_scoreboard sb;
  int unsigned          idle_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          bytes_sent = 0;
  int unsigned          texts_sent = 0;
  int unsigned          quiet_cycles = 0;
  logic [7:0]           text_q[$];

  logic [CodeBits-1:0] punct_pool [0:13] = '{
    'h28, 'h29, 'h2C, 'h2E, 'h5B, 'h7D, 'h3F, 'h3001, 'h3002, 'h300C, 'h300D,
    'hFF08, 'hFF09, 'h201C};

  utf8_line_break_classifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .start_offset_o (start_offset_o),
    .byte_length_o  (byte_length_o),
    .break_before_o (break_before_o),
    .space_flag_o   (space_flag_o),
    .char_class_o   (char_class_o),
    .newline_flag_o (newline_flag_o),
    .final_flag_o   (final_flag_o)
  );

  always #5 clk_i = ~clk_i;

  // result side: random stalls, check every accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({code_point_o, start_offset_o, byte_length_o, break_before_o,
                       space_flag_o, char_class_o, newline_flag_o, final_flag_o});
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_queue();
    int unsigned i;
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic append_cp(input logic [CodeBits-1:0] cp);
    if (cp < 'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic append_random_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) append_cp(21'($urandom_range('h7E, 'h21)));
    else if (pick < 40) append_cp($urandom_range(1) ? CP_SPACE : CP_TAB);
    else if (pick < 45) append_cp($urandom_range(3) == 0 ? CP_CR : CP_LF);
    else if (pick < 55) append_cp(punct_pool[$urandom_range(13)]);
    else if (pick < 62) append_cp(21'($urandom_range('h7FF, 'h80)));
    else if (pick < 70) append_cp(21'($urandom_range('h9FFF, 'h4E00)));
    else if (pick < 74) append_cp(21'($urandom_range('hD7AF, 'hAC00)));
    else if (pick < 78) append_cp(21'($urandom_range('h30FF, 'h3000)));
    else if (pick < 82) append_cp(21'($urandom_range('hFFFF, 'h800)));
    else if (pick < 86) append_cp(21'($urandom_range('h3FFFD, 'h20000)));
    else if (pick < 90) append_cp(21'($urandom_range('h1FFFFF, 'h10000)));
    else if (pick < 95) add_byte(8'($urandom_range(255, 'h80)));
    else add_byte(8'($urandom_range(255)));
  endtask

  task automatic send_random_text();
    int unsigned n;
    n = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
    repeat (n) append_random_char();
    // sometimes drop the last byte, which may cut the text inside its last sequence
    if (text_q.size() > 1 && $urandom_range(9) == 0) void'(text_q.pop_back());
    send_queue();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count);
    int unsigned goal;
    idle_pct  = idle;
    stall_pct = stall;
    goal = bytes_sent + count;
    while (bytes_sent < goal) send_random_text();
    drain();
  endtask

  initial begin
    logic [7:0] directed [0:23] = '{
      "a", " ", "b", 8'h00, 8'h0A, "(", "x", 8'hE4, 8'hB8, 8'h80, 8'hE3, 8'h80,
      8'h81, 8'hF0, 8'hA0, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hF8, 8'h7F, 8'h09,
      8'hE4, 8'hB8};
    int unsigned i;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ascii, space, null, line feed, brackets, cjk, 4-byte, stray leads,
    // tab and a text cut inside a sequence
    for (i = 0; i < 24; i++) send_byte(directed[i], i == 23);
    texts_sent++;
    drain();

    run_phase(0, 0, 410);
    run_phase(80, 0, 410);
    run_phase(0, 80, 410);
    run_phase(18, 18, 410);

    repeat (5) @(posedge clk_i);
    $display("summary: %0d bytes in %0d texts, %0d codepoints checked", bytes_sent,
             texts_sent, sb.checked);
    $display("summary: idle and stall phases, stray leads and truncated texts covered");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
